>>> rtl/lzt_pkg.sv
package lzt_pkg;

  // default history depth, the farthest offset a match may reach
  localparam int LztWindow = 20;

  localparam int ByteW = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_STEP
  } lzt_state_e;

  // per-token control broadcast to every match cell
  typedef struct packed {
    logic init;   // arm cells for a new token search
    logic shift;  // compare against lookahead head, then shift chain
  } lzt_cell_ctrl_t;

endpackage

>>> rtl/lzt_match_cell.sv
module lzt_match_cell #(
  parameter int OffW    = 5,
  parameter int CellOff = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lzt_pkg::lzt_cell_ctrl_t ctrl_i,
  input  logic [OffW-1:0]         hist_fill_i,
  input  logic [OffW-1:0]         step_idx_i,
  input  logic [7:0]              head_i,
  input  logic [7:0]              byte_i,
  output logic [7:0]              byte_o,
  output logic                    match_o
);
  import lzt_pkg::*;

  localparam logic [OffW-1:0] OffVal = OffW'(CellOff);

  logic [7:0] byte_q, byte_d;
  logic       alive_q, alive_d;

  // match still running after comparing this step, never past own offset
  assign match_o = alive_q && (byte_q == head_i) && (step_idx_i < OffVal);

  always_comb begin
    byte_d  = byte_q;
    alive_d = alive_q;
    if (ctrl_i.init) begin
      alive_d = (OffVal <= hist_fill_i);
    end else if (ctrl_i.shift) begin
      alive_d = match_o;
      byte_d  = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= 1'b0;
    end else begin
      alive_q <= alive_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

>>> rtl/lzt_lookahead.sv
module lzt_lookahead #(
  parameter int Window = lzt_pkg::LztWindow
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [7:0]                       push_byte_i,
  input  logic                             pop_i,
  output logic [7:0]                       head_o,
  output logic [$clog2(Window+2)-1:0]      fill_o
);
  import lzt_pkg::*;

  localparam int Depth = Window + 1;
  localparam int IdxW  = $clog2(Depth);
  localparam int FillW = $clog2(Window + 2);

  logic [7:0]       buf_q [Depth];
  logic [7:0]       buf_d [Depth];
  logic [FillW-1:0] fill_q, fill_d;
  logic [IdxW-1:0]  wr_idx;

  assign wr_idx = fill_q[IdxW-1:0];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      buf_d[i] = buf_q[i];
    end
    fill_d = fill_q;
    if (pop_i) begin
      // queue moves toward the head by one entry
      for (int i = 0; i < Depth - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      fill_d = fill_q - FillW'(1);
    end else if (push_i) begin
      for (int i = 0; i < Depth; i++) begin
        if (wr_idx == IdxW'(i)) begin
          buf_d[i] = push_byte_i;
        end
      end
      fill_d = fill_q + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

  assign head_o = buf_q[0];
  assign fill_o = fill_q;

endmodule

>>> rtl/lz77_greedy_tokenizer_unit.sv
// channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_stall_o   | data_byte_i, end_of_data_i
// output  | out       | out_valid_o / out_stall_i | match_offset_o, match_length_o,
//         |           |                           | next_byte_o, next_past_end_o,
//         |           |                           | run_last_o, stream_done_o
//
// a byte that completes no token is accepted straight from the idle state
// a token takes an arming step in ST_INIT, then compare steps in ST_STEP,
// each consuming one lookahead byte, the last one the literal unless the match
// runs to stream end; the shared compare step of the cell chain paces every token
// reset clears the fill counts and control; history and lookahead bytes are
// left as they are and are only read below the fill counts
// a stalled output transaction holds the final compare step of the next token
module lz77_greedy_tokenizer_unit #(
  parameter int WINDOW = lzt_pkg::LztWindow
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          end_of_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [$clog2(WINDOW+1)-1:0]   match_offset_o,
  output logic [$clog2(WINDOW+1)-1:0]   match_length_o,
  output logic [7:0]                    next_byte_o,
  output logic                          next_past_end_o,
  output logic                          run_last_o,
  output logic                          stream_done_o
);
  import lzt_pkg::*;

  localparam int OffW  = $clog2(WINDOW + 1);
  localparam int FillW = $clog2(WINDOW + 2);

  lzt_state_e     state_q, state_d;
  lzt_cell_ctrl_t cell_ctrl;

  logic             flush_q, flush_d;      // end flag seen, drain lookahead
  logic [OffW-1:0]  hist_fill_q, hist_fill_d;
  logic [OffW-1:0]  step_q, step_d;        // bytes matched so far in this token
  logic [OffW-1:0]  best_off_q, best_off_d;

  logic             in_accept;
  logic             la_push, la_pop;
  logic [7:0]       la_head;
  logic [FillW-1:0] la_fill, fill_left;

  logic [WINDOW-1:0] cell_match;
  logic [7:0]        cell_byte [WINDOW];
  logic              any_match;
  logic [OffW-1:0]   far_off;

  logic             tok_done, tok_past, tok_end, out_free, step_en;
  logic [OffW-1:0]  tok_off, tok_len;

  // output register, parts the compare chain from the output side
  logic             out_valid_q, out_valid_d;
  logic [OffW-1:0]  off_q, len_q;
  logic [7:0]       nb_q;
  logic             past_q, last_q, done_q;

  // --------------------------------------------------------------------
  // lookahead queue, head feeds the compare broadcast
  // --------------------------------------------------------------------
  lzt_lookahead #(
    .Window (WINDOW)
  ) u_lookahead (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (la_push),
    .push_byte_i (data_byte_i),
    .pop_i       (la_pop),
    .head_o      (la_head),
    .fill_o      (la_fill)
  );

  // --------------------------------------------------------------------
  // cell chain: cell g sits at offset g+1 and holds that history byte;
  // every step shifts the chain by one so the head byte enters cell 0,
  // which leaves the chain holding the updated history after the token
  // --------------------------------------------------------------------
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    logic [7:0] feed;
    if (g == 0) begin : g_first
      assign feed = la_head;
    end else begin : g_rest
      assign feed = cell_byte[g-1];
    end

    lzt_match_cell #(
      .OffW    (OffW),
      .CellOff (g + 1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .hist_fill_i (hist_fill_q),
      .step_idx_i  (step_q),
      .head_i      (la_head),
      .byte_i      (feed),
      .byte_o      (cell_byte[g]),
      .match_o     (cell_match[g])
    );
  end

  assign any_match = |cell_match;

  // all live cells share one length, so the farthest live cell wins ties
  always_comb begin
    far_off = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (cell_match[k]) begin
        far_off = OffW'(k + 1);
      end
    end
  end

  // --------------------------------------------------------------------
  // token completion
  // --------------------------------------------------------------------
  assign fill_left = la_fill - FillW'(1);
  // no cell survives this step, or the match just swallowed the lookahead
  assign tok_past  = any_match && (la_fill == FillW'(1));
  assign tok_done  = !any_match || tok_past;
  assign tok_off   = any_match ? far_off : best_off_q;
  assign tok_len   = any_match ? (step_q + OffW'(1)) : step_q;
  assign tok_end   = flush_q && (fill_left == '0);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_en   = (state_q == ST_STEP) && (!tok_done || out_free);
  assign in_accept = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (end_of_data_i || (la_fill == FillW'(WINDOW))) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        if (step_en && tok_done) begin
          state_d = (flush_q && !tok_end) ? ST_INIT : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    la_push         = in_accept;
    la_pop          = step_en;
    cell_ctrl.init  = (state_q == ST_INIT);
    cell_ctrl.shift = step_en;
  end

  always_comb begin
    flush_d     = flush_q;
    hist_fill_d = hist_fill_q;
    step_d      = step_q;
    best_off_d  = best_off_q;
    if (in_accept) begin
      flush_d = end_of_data_i;
    end
    if (state_q == ST_INIT) begin
      step_d     = '0;
      best_off_d = '0;
    end
    if (step_en) begin
      step_d = step_q + OffW'(1);
      if (any_match) begin
        best_off_d = far_off;
      end
      // one byte enters history per step, saturating at the window
      if (hist_fill_q != OffW'(WINDOW)) begin
        hist_fill_d = hist_fill_q + OffW'(1);
      end
      // end of stream: next byte starts an independent stream
      if (tok_done && tok_end) begin
        hist_fill_d = '0;
        flush_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flush_q     <= 1'b0;
      hist_fill_q <= '0;
      step_q      <= '0;
      best_off_q  <= '0;
    end else begin
      state_q     <= state_d;
      flush_q     <= flush_d;
      hist_fill_q <= hist_fill_d;
      step_q      <= step_d;
      best_off_q  <= best_off_d;
    end
  end

  // --------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (step_en && tok_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && tok_done) begin
      off_q  <= tok_off;
      len_q  <= tok_len;
      nb_q   <= tok_past ? 8'd0 : la_head;
      past_q <= tok_past;
      // a running stream gives one token per byte, a flush gives many
      last_q <= !flush_q || tok_end;
      done_q <= tok_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_offset_o  = off_q;
  assign match_length_o  = len_q;
  assign next_byte_o     = nb_q;
  assign next_past_end_o = past_q;
  assign run_last_o      = last_q;
  assign stream_done_o   = done_q;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // self-checking bench for the greedy lz77 token encoder
  // a behavioral coder in this file tracks history and lookahead per accepted
  // byte and queues the tokens it expects; every token leaving the block is
  // compared field by field against the oldest queued one

  import lzt_pkg::*;

  localparam int Window     = LztWindow;
  localparam int OffW       = $clog2(Window + 1);
  localparam int CycleLimit = 400000;
  // longest token is an arming step followed by compare steps over the whole lookahead
  localparam int SettleCycles = 3 * (Window + 3);

  // one token as it leaves the block
  typedef struct packed {
    logic [OffW-1:0]  offset;
    logic [OffW-1:0]  length;
    logic [ByteW-1:0] nbyte;
    logic             past_end;
    logic             run_last;
    logic             done;
  } lz_token_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i = '0;
  logic             end_of_data_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [OffW-1:0]  match_offset_o;
  logic [OffW-1:0]  match_length_o;
  logic [7:0]       next_byte_o;
  logic             next_past_end_o;
  logic             run_last_o;
  logic             stream_done_o;

  // tokens still owed by the block, oldest first
  lz_token_t expected_tokens[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // idle rates in percent; the receiver rate goes through a nonblocking write
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // long receiver hold-off, requested by bumping hold_seq
  int        hold_len = 0;
  int        hold_seq = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  // coder state: coded bytes (oldest first) and pending bytes
  logic [ByteW-1:0] coded_bytes [Window];
  int               coded_cnt = 0;
  logic [ByteW-1:0] pending_bytes [Window+1];
  int               pending_cnt = 0;

  lz77_greedy_tokenizer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_data_i   (end_of_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .match_offset_o  (match_offset_o),
    .match_length_o  (match_length_o),
    .next_byte_o     (next_byte_o),
    .next_past_end_o (next_past_end_o),
    .run_last_o      (run_last_o),
    .stream_done_o   (stream_done_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // token coder
  // ---------------------------------------------------------------------

  // append one coded byte, dropping the oldest once the window is full
  function automatic void remember_byte(input logic [ByteW-1:0] b);
    if (coded_cnt < Window) begin
      coded_bytes[coded_cnt] = b;
      coded_cnt++;
    end else begin
      for (int k = 0; k < Window - 1; k++) coded_bytes[k] = coded_bytes[k+1];
      coded_bytes[Window-1] = b;
    end
  endfunction

  // greedy search over all offsets, farthest first; only a strictly longer
  // run replaces the best so ties keep the farther offset
  function automatic void code_next_token(output lz_token_t tok);
    int   best_len;
    int   best_off;
    int   run;
    int   used;
    logic past;
    best_len = 0;
    best_off = 0;
    for (int off = coded_cnt; off >= 1; off--) begin
      run = 0;
      // a match never reaches past the current position, so run <= off
      while (run < off && run < pending_cnt &&
             coded_bytes[coded_cnt - off + run] == pending_bytes[run])
        run++;
      if (run > best_len) begin
        best_len = run;
        best_off = off;
      end
    end
    // match covering the whole lookahead only happens during the flush
    past = (best_len == pending_cnt);
    tok.offset   = OffW'(best_off);
    tok.length   = OffW'(best_len);
    tok.nbyte    = past ? '0 : pending_bytes[best_len];
    tok.past_end = past;
    tok.run_last = 1'b0;
    tok.done     = 1'b0;
    used = past ? best_len : best_len + 1;
    if (used > pending_cnt) used = pending_cnt;
    for (int k = 0; k < used; k++) remember_byte(pending_bytes[k]);
    for (int k = 0; k + used < pending_cnt; k++) pending_bytes[k] = pending_bytes[k+used];
    pending_cnt -= used;
  endfunction

  // queue the tokens one accepted byte gives rise to
  function automatic void predict_tokens(input logic [7:0] b, input logic eod);
    lz_token_t tok;
    int        n;
    if (pending_cnt < Window + 1) begin
      pending_bytes[pending_cnt] = b;
      pending_cnt++;
    end
    if (eod) begin
      // flush until the lookahead is empty, then start a fresh stream
      n = 0;
      while (pending_cnt > 0 && n < Window + 1) begin
        code_next_token(tok);
        n++;
        if (pending_cnt == 0 || n == Window + 1) begin
          tok.run_last = 1'b1;
          tok.done     = 1'b1;
        end
        expected_tokens.push_back(tok);
      end
      coded_cnt   = 0;
      pending_cnt = 0;
    end else if (pending_cnt == Window + 1) begin
      // lookahead just became full: exactly one token
      code_next_token(tok);
      tok.run_last = 1'b1;
      expected_tokens.push_back(tok);
    end
  endfunction

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("token check %s: expected %0d, got %0d", what, want_v, got_v);
  endtask

  // receiver stall: a requested hold-off first, else random per phase
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen   <= hold_seq;
      hold_left   <= hold_len;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // compare every accepted token against the oldest expectation
  always @(posedge clk_i) begin : check_tokens
    lz_token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        note_mismatch("unexpected token, queued count", 0, 1);
      end else begin
        want = expected_tokens.pop_front();
        if (match_offset_o !== want.offset)
          note_mismatch("match_offset", 32'(want.offset), 32'(match_offset_o));
        if (match_length_o !== want.length)
          note_mismatch("match_length", 32'(want.length), 32'(match_length_o));
        if (next_byte_o !== want.nbyte)
          note_mismatch("next_byte", 32'(want.nbyte), 32'(next_byte_o));
        if (next_past_end_o !== want.past_end)
          note_mismatch("next_past_end", 32'(want.past_end), 32'(next_past_end_o));
        if (run_last_o !== want.run_last)
          note_mismatch("run_last", 32'(want.run_last), 32'(run_last_o));
        if (stream_done_o !== want.done)
          note_mismatch("stream_done", 32'(want.done), 32'(stream_done_o));
      end
    end
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // offer one byte, with random gaps ahead of it, and hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_data_i <= eod;
    do @(posedge clk_i); while (in_stall_o);
    predict_tokens(b, eod);
  endtask

  // drop valid and wait until every expected token has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // one stream of random shape: noise, two-symbol text, or a short or
  // long repeating pattern with the odd corrupted byte
  task automatic send_random_stream(input int len);
    int         mode;
    int         period;
    logic [7:0] sym_a;
    logic [7:0] sym_b;
    logic [7:0] pattern [Window+1];
    logic [7:0] b;
    mode   = $urandom_range(0, 9);
    period = ($urandom_range(0, 3) == 0) ? $urandom_range(7, Window + 1)
                                         : $urandom_range(1, 6);
    sym_a  = 8'($urandom);
    sym_b  = 8'($urandom);
    for (int k = 0; k <= Window; k++) pattern[k] = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      if (mode < 2) begin
        b = 8'($urandom);
      end else if (mode < 5) begin
        b = $urandom_range(0, 1) ? sym_a : sym_b;
      end else begin
        b = pattern[i % period];
        if ($urandom_range(0, 19) == 0) b = 8'($urandom);
      end
      send_byte(b, i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // one-byte stream: a single literal that also closes the stream
  task automatic test_literal_token();
    send_byte(8'hFF, 1'b1);
  endtask

  // a run of equal bytes ends in a match that reaches the stream end
  task automatic test_match_to_stream_end();
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // repeating pair: matches limited by their offset, no token before flush
  task automatic test_repeating_pair();
    repeat (3) begin
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
    end
    send_byte(8'hA5, 1'b1);
  endtask

  // after a flush the history is gone, so the same bytes are literals again
  task automatic test_flush_restarts_stream();
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
  endtask

  // random streams until n bytes were sent
  task automatic test_random_traffic(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(Window + 2, 3 * Window)
                                        : $urandom_range(1, Window + 4);
      if (len > n - sent) len = n - sent;
      send_random_stream(len);
      sent += len;
    end
  endtask

  // receiver holds off for a long stretch while bytes keep coming, so the
  // block fills up and stalls its input
  task automatic test_output_holdoff();
    hold_len <= 400;
    hold_seq <= hold_seq + 1;
    send_random_stream(Window + 8);
  endtask

  // sender stops mid-stream until the block has caught up, then finishes
  task automatic test_pause_until_drained();
    for (int i = 0; i < Window + 2; i++) send_byte(($urandom_range(0, 2) == 0) ?
                                                   8'($urandom) : 8'h5C, 1'b0);
    wait_drained();
    send_byte(8'h5C, 1'b0);
    send_byte(8'h3A, 1'b1);
  endtask

  initial begin
    set_idling(15, 73);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_literal_token();
    test_match_to_stream_end();
    test_repeating_pair();
    test_flush_restarts_stream();

    // sender mostly busy, receiver mostly stalled
    test_random_traffic(22);
    // the other way round
    set_idling(73, 15);
    test_random_traffic(22);
    // full rate both sides
    set_idling(0, 0);
    test_random_traffic(22);
    test_output_holdoff();
    test_pause_until_drained();

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    while (expected_tokens.size() != 0) begin
      void'(expected_tokens.pop_front());
      note_mismatch("missing token, still queued", 0, 1);
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lzt_pkg.sv
rtl/lzt_match_cell.sv
rtl/lzt_lookahead.sv
rtl/lz77_greedy_tokenizer_unit.sv
verif/testbench.sv
